// ===== hw/rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, codes and command helpers for the SPI-mode SD block sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

  // default sizing of the transfer
  localparam int DEF_BLOCK_BYTES = 512;
  localparam int DEF_RESP_TRIES  = 255;
  localparam int DEF_BUSY_TRIES  = 65535;

  // field widths
  localparam int SHIFT_W = 4;
  localparam int POLL_W  = 16;
  localparam int ADDR_W  = 3;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 24;

  // register map
  localparam logic [ADDR_W-1:0] REG_ADDRESS_SHIFT = 3'd0;
  localparam logic [SHIFT_W-1:0] ADDRESS_SHIFT_RST = 4'd9;

  // bytes on the wire
  localparam logic [7:0] CMD17_OP    = 8'h51;
  localparam logic [7:0] CMD24_OP    = 8'h58;
  localparam logic [7:0] DATA_TOKEN  = 8'hFE;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [3:0] DRESP_MASK  = 4'hF;
  localparam logic [3:0] DRESP_OK    = 4'h5;

  // request kinds on the input stream
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_XCHG  = 2'd2
  } mode_t;

  // transfer outcome
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_RD_CMD_TO   = 3'd1,
    ST_TOKEN_MISS  = 3'd2,
    ST_WR_CMD_TO   = 3'd3,
    ST_WR_REJECT   = 3'd4,
    ST_BUSY_TO     = 3'd5
  } status_t;

  // sequencer phases
  typedef enum logic [11:0] {
    PH_IDLE   = 12'b0000_0000_0001,
    PH_CMD    = 12'b0000_0000_0010,
    PH_R1     = 12'b0000_0000_0100,
    PH_TOKEN  = 12'b0000_0000_1000,
    PH_RDATA  = 12'b0000_0001_0000,
    PH_RCRC   = 12'b0000_0010_0000,
    PH_WTOKEN = 12'b0000_0100_0000,
    PH_WDATA  = 12'b0000_1000_0000,
    PH_WCRC   = 12'b0001_0000_0000,
    PH_WRESP  = 12'b0010_0000_0000,
    PH_BUSY   = 12'b0100_0000_0000,
    PH_TRAIL  = 12'b1000_0000_0000
  } phase_t;

  // one result, first member in the high bits so mosi_valid lands at bit 0
  typedef struct packed {
    status_t    status;
    logic       done_res;
    logic       write_byte_used;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       card_select;
    logic [7:0] mosi_byte;
    logic       mosi_valid;
  } res_t;

  // byte idx of the six-byte command frame
  function automatic logic [7:0] cmd_byte(input logic wr, input logic [31:0] addr,
                                          input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = wr ? CMD24_OP : CMD17_OP;
      3'd1: b = addr[31:24];
      3'd2: b = addr[23:16];
      3'd3: b = addr[15:8];
      3'd4: b = addr[7:0];
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sd_spi_block_transfer_top.sv =====
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_top
// SPI-mode SD host sequencer for one block read (CMD17) or write (CMD24).
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_axis   | in        | s_tvalid/s_tready  | tuser: mode; tdata: block, miso, wr
//  m_axis   | out       | m_tvalid/m_tready  | tdata: one result per request
//  apb      | in        | psel/penable/pready| address_shift at byte address 0
//
//  One request is taken per cycle while the skid register is empty; its result
//  goes to the output register, or to the skid register if the output stalls.
//  The decode is a single pass from request and phase register to result register.
//  A skid register behind the output register keeps s_tready a flop, so a
//  stalled sink costs one buffered result before the input side stops.
//  Reset puts the sequencer idle and address_shift to 9.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_block_transfer_top #(
  parameter int BLOCK_BYTES = sdspi_pkg::DEF_BLOCK_BYTES,
  parameter int RESP_TRIES  = sdspi_pkg::DEF_RESP_TRIES,
  parameter int BUSY_TRIES  = sdspi_pkg::DEF_BUSY_TRIES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [sdspi_pkg::IN_W-1:0]   s_tdata,  // block_number, miso_byte, write_byte
  input  wire logic [1:0]                   s_tuser,  // mode
  // output stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [sdspi_pkg::OUT_W-1:0]       m_tdata,  // mosi_valid, mosi_byte, card_select,
                                                      // read_valid, read_byte,
                                                      // write_byte_used, done_res, status
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sdspi_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int BI_W = $clog2(BLOCK_BYTES + 1);
  localparam int PC_W = sdspi_pkg::POLL_W;

  // configuration register
  logic [sdspi_pkg::SHIFT_W-1:0] address_shift;
  logic                          reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr == sdspi_pkg::REG_ADDRESS_SHIFT);
  assign prdata  = reg_hit ? {{(32-sdspi_pkg::SHIFT_W){1'b0}}, address_shift} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_shift <= sdspi_pkg::ADDRESS_SHIFT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      address_shift <= pwdata[sdspi_pkg::SHIFT_W-1:0];
    end
  end

  // request fields
  sdspi_pkg::mode_t mode;
  logic [31:0]      block_number;
  logic [7:0]       miso_byte;
  logic [7:0]       write_byte;

  assign mode         = sdspi_pkg::mode_t'(s_tuser);
  assign block_number = s_tdata[31:0];
  assign miso_byte    = s_tdata[39:32];
  assign write_byte   = s_tdata[47:40];

  // sequencer state
  sdspi_pkg::phase_t phase, phase_next;
  logic              is_write, is_write_next;
  logic [31:0]       card_address, card_address_next;
  logic [BI_W-1:0]   byte_index, byte_index_next;
  logic [PC_W-1:0]   poll_count, poll_count_next;

  logic [BI_W-1:0]   bi_inc;
  logic [PC_W-1:0]   pc_inc;
  sdspi_pkg::res_t   res;
  logic              s_acc;

  assign s_acc  = s_tvalid && s_tready;
  assign bi_inc = byte_index + BI_W'(1);
  assign pc_inc = poll_count + PC_W'(1);

  // one-pass decode of the request against the current phase
  always_comb begin
    res               = '0;
    phase_next        = phase;
    is_write_next     = is_write;
    card_address_next = card_address;
    byte_index_next   = byte_index;
    poll_count_next   = poll_count;

    if (mode == sdspi_pkg::MODE_READ || mode == sdspi_pkg::MODE_WRITE) begin
      // start always opens a new transfer
      is_write_next     = (mode == sdspi_pkg::MODE_WRITE);
      card_address_next = block_number << address_shift;
      byte_index_next   = '0;
      poll_count_next   = '0;
      phase_next        = sdspi_pkg::PH_CMD;
      res.mosi_valid    = 1'b1;
      res.card_select   = 1'b1;
      res.mosi_byte     = (mode == sdspi_pkg::MODE_WRITE) ? sdspi_pkg::CMD24_OP
                                                          : sdspi_pkg::CMD17_OP;
    end else if (mode == sdspi_pkg::MODE_XCHG) begin
      case (phase)
        sdspi_pkg::PH_CMD: begin
          byte_index_next = bi_inc;
          res.mosi_valid  = 1'b1;
          res.card_select = 1'b1;
          if (bi_inc < BI_W'(6)) begin
            res.mosi_byte = sdspi_pkg::cmd_byte(is_write, card_address, bi_inc[2:0]);
          end else begin
            phase_next      = sdspi_pkg::PH_R1;
            poll_count_next = '0;
            res.mosi_byte   = sdspi_pkg::FILL_BYTE;
          end
        end
        sdspi_pkg::PH_R1: begin
          poll_count_next = pc_inc;
          if (miso_byte == sdspi_pkg::R1_READY) begin
            poll_count_next = '0;
            res.mosi_valid  = 1'b1;
            res.card_select = 1'b1;
            if (is_write) begin
              phase_next    = sdspi_pkg::PH_WTOKEN;
              res.mosi_byte = sdspi_pkg::DATA_TOKEN;
            end else begin
              phase_next    = sdspi_pkg::PH_TOKEN;
              res.mosi_byte = sdspi_pkg::FILL_BYTE;
            end
          end else if (pc_inc >= PC_W'(RESP_TRIES)) begin
            phase_next   = sdspi_pkg::PH_IDLE;
            res.done_res = 1'b1;
            res.status   = is_write ? sdspi_pkg::ST_WR_CMD_TO : sdspi_pkg::ST_RD_CMD_TO;
          end else begin
            res.mosi_valid  = 1'b1;
            res.card_select = 1'b1;
            res.mosi_byte   = sdspi_pkg::FILL_BYTE;
          end
        end
        sdspi_pkg::PH_TOKEN: begin
          poll_count_next = pc_inc;
          if (miso_byte == sdspi_pkg::DATA_TOKEN) begin
            phase_next      = sdspi_pkg::PH_RDATA;
            byte_index_next = '0;
            res.mosi_valid  = 1'b1;
            res.card_select = 1'b1;
            res.mosi_byte   = sdspi_pkg::FILL_BYTE;
          end else if (pc_inc >= PC_W'(RESP_TRIES)) begin
            phase_next   = sdspi_pkg::PH_IDLE;
            res.done_res = 1'b1;
            res.status   = sdspi_pkg::ST_TOKEN_MISS;
          end else begin
            res.mosi_valid  = 1'b1;
            res.card_select = 1'b1;
            res.mosi_byte   = sdspi_pkg::FILL_BYTE;
          end
        end
        sdspi_pkg::PH_RDATA: begin
          res.read_valid  = 1'b1;
          res.read_byte   = miso_byte;
          byte_index_next = bi_inc;
          if (bi_inc >= BI_W'(BLOCK_BYTES)) begin
            phase_next      = sdspi_pkg::PH_RCRC;
            byte_index_next = '0;
          end
          res.mosi_valid  = 1'b1;
          res.card_select = 1'b1;
          res.mosi_byte   = sdspi_pkg::FILL_BYTE;
        end
        sdspi_pkg::PH_RCRC: begin
          byte_index_next = bi_inc;
          res.mosi_valid  = 1'b1;
          res.mosi_byte   = sdspi_pkg::FILL_BYTE;
          if (bi_inc < BI_W'(2)) begin
            res.card_select = 1'b1;
          end else begin
            // deselect for the trailing clocks
            phase_next      = sdspi_pkg::PH_TRAIL;
            res.card_select = 1'b0;
          end
        end
        sdspi_pkg::PH_WTOKEN: begin
          phase_next          = sdspi_pkg::PH_WDATA;
          byte_index_next     = BI_W'(1);
          res.write_byte_used = 1'b1;
          res.mosi_valid      = 1'b1;
          res.card_select     = 1'b1;
          res.mosi_byte       = write_byte;
        end
        sdspi_pkg::PH_WDATA: begin
          res.mosi_valid  = 1'b1;
          res.card_select = 1'b1;
          if (byte_index < BI_W'(BLOCK_BYTES)) begin
            byte_index_next     = bi_inc;
            res.write_byte_used = 1'b1;
            res.mosi_byte       = write_byte;
          end else begin
            phase_next      = sdspi_pkg::PH_WCRC;
            byte_index_next = '0;
            res.mosi_byte   = sdspi_pkg::FILL_BYTE;
          end
        end
        sdspi_pkg::PH_WCRC: begin
          byte_index_next = bi_inc;
          if (bi_inc >= BI_W'(2)) begin
            phase_next = sdspi_pkg::PH_WRESP;
          end
          res.mosi_valid  = 1'b1;
          res.card_select = 1'b1;
          res.mosi_byte   = sdspi_pkg::FILL_BYTE;
        end
        sdspi_pkg::PH_WRESP: begin
          if ((miso_byte[3:0] & sdspi_pkg::DRESP_MASK) != sdspi_pkg::DRESP_OK) begin
            phase_next   = sdspi_pkg::PH_IDLE;
            res.done_res = 1'b1;
            res.status   = sdspi_pkg::ST_WR_REJECT;
          end else begin
            phase_next      = sdspi_pkg::PH_BUSY;
            poll_count_next = '0;
            res.mosi_valid  = 1'b1;
            res.card_select = 1'b1;
            res.mosi_byte   = sdspi_pkg::FILL_BYTE;
          end
        end
        sdspi_pkg::PH_BUSY: begin
          poll_count_next = pc_inc;
          if (miso_byte != sdspi_pkg::R1_READY) begin
            phase_next     = sdspi_pkg::PH_TRAIL;
            res.mosi_valid = 1'b1;
            res.mosi_byte  = sdspi_pkg::FILL_BYTE;
          end else if (pc_inc >= PC_W'(BUSY_TRIES)) begin
            phase_next   = sdspi_pkg::PH_IDLE;
            res.done_res = 1'b1;
            res.status   = sdspi_pkg::ST_BUSY_TO;
          end else begin
            res.mosi_valid  = 1'b1;
            res.card_select = 1'b1;
            res.mosi_byte   = sdspi_pkg::FILL_BYTE;
          end
        end
        sdspi_pkg::PH_TRAIL: begin
          phase_next   = sdspi_pkg::PH_IDLE;
          res.done_res = 1'b1;
          res.status   = sdspi_pkg::ST_OK;
        end
        default: begin
          // idle: exchange ignored
        end
      endcase
    end
  end

  // state update on each taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sdspi_pkg::PH_IDLE;
      is_write     <= 1'b0;
      card_address <= '0;
      byte_index   <= '0;
      poll_count   <= '0;
    end else if (s_acc) begin
      phase        <= phase_next;
      is_write     <= is_write_next;
      card_address <= card_address_next;
      byte_index   <= byte_index_next;
      poll_count   <= poll_count_next;
    end
  end

  // output register with skid
  sdspi_pkg::res_t out_q, skid_q;
  logic            skid_valid;

  assign s_tready = !skid_valid;
  assign m_tdata  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= s_acc;
      end
    end else if (s_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (s_acc) begin
        out_q <= res;
      end
    end else if (s_acc) begin
      skid_q <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sdspi_checker.sv =====
// ----------------------------------------------------------------------------
// sdspi_checker
// Port-level checks on the result stream of the SD block sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [sdspi_pkg::OUT_W-1:0] m_tdata
);

  sdspi_pkg::res_t r;
  assign r = m_tdata;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // status only carries meaning on the ending result
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r.done_res |-> r.status == sdspi_pkg::ST_OK)
    else $error("status without done");

  // the ending result leaves the bus idle and deselected
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.done_res |-> !r.mosi_valid && !r.card_select && !r.read_valid)
    else $error("exchange requested with done");

  // read data and write data never in the same exchange
  a_rw_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(r.read_valid && r.write_byte_used))
    else $error("read and write byte in one result");

endmodule

bind sd_spi_block_transfer_top sdspi_checker u_sdspi_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
